FILE: src/cvs_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity shared definitions
// Command and status groups between controller and datapath, plus fixed
// widths of the divide and square-root stages.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // Quotient bits of the norm divide (ratio below 2^60 unless saturated)
  localparam int unsigned QW = 60;
  // Root bits produced by the square-root stage
  localparam int unsigned RW = 30;
  // Square-root partial remainder width
  localparam int unsigned SRW = RW + 2;

  // Plus one in Q1.30, as a magnitude
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic acc;         // add a non-final pair into the running sums
    logic cap;         // final pair: latch operands, clear sums, load norm product
    logic mul_step;    // one shift-add multiplier step
    logic ld_d;        // keep norm product, load dot magnitude square
    logic div_init;    // set up divide, flag saturation
    logic div_step;    // one restoring divide step
    logic cnt_clr;     // restart the step counter
    logic sqrt_step;   // one square-root digit
    logic out_load;    // write result into the output register
  } cvs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_last;
    logic div_last;
    logic sqrt_last;
    logic div_sat;
    logic out_free;
  } cvs_sts_t;

endpackage

FILE: src/cvs_ctrl.sv
// ----------------------------------------------------------------------------
// Cosine similarity controller
// Sequences accumulation, the two shift-add products, the divide, the square
// root and the result hand-off.
// ----------------------------------------------------------------------------
module cvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_pair_i,
  input  cvs_pkg::cvs_sts_t sts_i,
  output logic              in_ready_o,
  output cvs_pkg::cvs_cmd_t cmd_o
);
  import cvs_pkg::*;

  typedef enum logic [7:0] {
    S_ACC  = 8'b0000_0001,
    S_MULP = 8'b0000_0010,
    S_LDD  = 8'b0000_0100,
    S_MULD = 8'b0000_1000,
    S_DIVC = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } cvs_state_e;

  cvs_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (last_pair_i) begin
            cmd_o.cap = 1'b1;
            state_d   = S_MULP;
          end else begin
            cmd_o.acc = 1'b1;
          end
        end
      end
      S_MULP: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = S_LDD;
      end
      S_LDD: begin
        cmd_o.ld_d = 1'b1;
        state_d    = S_MULD;
      end
      S_MULD: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = S_DIVC;
      end
      S_DIVC: begin
        cmd_o.div_init = 1'b1;
        state_d        = sts_i.div_sat ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/cvs_datapath.sv
// ----------------------------------------------------------------------------
// Cosine similarity datapath
// Saturating sums, a shared shift-add multiplier, a restoring divider, a
// digit-by-digit square root and the output register.
// ----------------------------------------------------------------------------
module cvs_datapath #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [15:0]  a_elem_i,
  input  logic signed [15:0]  b_elem_i,
  input  cvs_pkg::cvs_cmd_t   cmd_i,
  input  logic                out_ready_i,
  output cvs_pkg::cvs_sts_t   sts_o,
  output logic                out_valid_o,
  output logic signed [31:0]  similarity_o,
  output logic                zero_norm_o
);
  import cvs_pkg::*;

  // Norm sum width, dot sum width, square width
  localparam int unsigned NW      = $clog2(MAX_DIM) + 31;
  localparam int unsigned DW      = NW + 1;
  localparam int unsigned PW      = 2 * NW;
  localparam int unsigned CntMax  = (NW > QW) ? NW : QW;
  localparam int unsigned CntW    = $clog2(CntMax);
  localparam longint unsigned SumLimL = longint'(MAX_DIM) << 30;
  localparam logic [NW-1:0]       SumLim = SumLimL[NW-1:0];
  localparam logic signed [DW:0]  DotHi  = $signed({2'b00, SumLim});
  localparam logic signed [DW:0]  DotLo  = -DotHi;
  localparam logic [NW:0]         NormHi = {1'b0, SumLim};

  // Running sums
  logic signed [DW-1:0] dot_q;
  logic [NW-1:0]        na_q, nb_q;
  // Final operands and flags
  logic [NW-1:0]        mag_q;
  logic                 sign_q, zero_q, sat_q;
  // Multiplier
  logic [PW-1:0]        mcand_q, prod_q, p_q;
  logic [NW-1:0]        mplr_q;
  // Divider and square root
  logic [PW-1:0]        rem_q;
  logic [QW-1:0]        quo_q;
  logic [SRW-1:0]       srem_q;
  logic [RW-1:0]        root_q;
  logic [CntW-1:0]      cnt_q;
  // Output register
  logic                 out_valid_q;
  logic signed [31:0]   sim_q;
  logic                 zn_q;

  // Element products
  logic signed [31:0] ab, aa, bb;
  assign ab = a_elem_i * b_elem_i;
  assign aa = a_elem_i * a_elem_i;
  assign bb = b_elem_i * b_elem_i;

  // Saturating sum updates
  logic signed [DW:0]   dot_w;
  logic signed [DW-1:0] dot_n, dot_abs;
  logic [NW:0]          na_w, nb_w;
  logic [NW-1:0]        na_n, nb_n, mag_n;

  always_comb begin
    dot_w = $signed({{(DW + 1 - 32){ab[31]}}, ab}) + $signed({dot_q[DW-1], dot_q});
    if (dot_w > DotHi) begin
      dot_n = DotHi[DW-1:0];
    end else if (dot_w < DotLo) begin
      dot_n = DotLo[DW-1:0];
    end else begin
      dot_n = dot_w[DW-1:0];
    end
    na_w    = {1'b0, na_q} + {{(NW - 30){1'b0}}, aa[30:0]};
    nb_w    = {1'b0, nb_q} + {{(NW - 30){1'b0}}, bb[30:0]};
    na_n    = (na_w > NormHi) ? SumLim : na_w[NW-1:0];
    nb_n    = (nb_w > NormHi) ? SumLim : nb_w[NW-1:0];
    dot_abs = dot_n[DW-1] ? -dot_n : dot_n;
    mag_n   = dot_abs[NW-1:0];
  end

  // Divide step: shift remainder, subtract divisor when it fits
  logic [PW:0] div_t, div_s;
  logic        div_ge;
  assign div_t  = {rem_q, 1'b0};
  assign div_ge = div_t >= {1'b0, p_q};
  assign div_s  = div_t - {1'b0, p_q};

  // Square-root step: bring down two quotient bits, try 4*root+1
  logic [SRW+1:0] sq_t, sq_trial, sq_s;
  logic           sq_ge;
  assign sq_t     = {srem_q, quo_q[QW-1:QW-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_s     = sq_t - sq_trial;

  // Result formatting
  logic [30:0] res_mag;
  logic [31:0] res_pos;
  logic [31:0] sim_n;
  always_comb begin
    res_mag = sat_q ? ONE_Q30 : {1'b0, root_q};
    res_pos = {1'b0, res_mag};
    if (zero_q) begin
      sim_n = '0;
    end else if (sign_q) begin
      sim_n = -res_pos;
    end else begin
      sim_n = res_pos;
    end
  end

  // Status
  always_comb begin
    sts_o           = '0;
    sts_o.mul_last  = (cnt_q == CntW'(NW - 1));
    sts_o.div_last  = (cnt_q == CntW'(QW - 1));
    sts_o.sqrt_last = (cnt_q == CntW'(RW - 1));
    sts_o.div_sat   = (prod_q >= p_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Sums, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else if (cmd_i.acc) begin
        dot_q <= dot_n;
        na_q  <= na_n;
        nb_q  <= nb_n;
      end
      if (cmd_i.cap || cmd_i.ld_d || cmd_i.div_init || cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.mul_step || cmd_i.div_step || cmd_i.sqrt_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operands, multiplier, divider, root and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mag_q   <= mag_n;
      sign_q  <= dot_n[DW-1];
      zero_q  <= (na_n == '0) || (nb_n == '0);
      mcand_q <= {{NW{1'b0}}, na_n};
      mplr_q  <= nb_n;
      prod_q  <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mplr_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q <= {mcand_q[PW-2:0], 1'b0};
      mplr_q  <= {1'b0, mplr_q[NW-1:1]};
    end
    if (cmd_i.ld_d) begin
      p_q     <= prod_q;
      mcand_q <= {{NW{1'b0}}, mag_q};
      mplr_q  <= mag_q;
      prod_q  <= '0;
    end
    if (cmd_i.div_init) begin
      sat_q  <= sts_o.div_sat;
      rem_q  <= prod_q;
      quo_q  <= '0;
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_s[PW-1:0] : div_t[PW-1:0];
      quo_q <= {quo_q[QW-2:0], div_ge};
    end
    if (cmd_i.sqrt_step) begin
      srem_q <= sq_ge ? sq_s[SRW-1:0] : sq_t[SRW-1:0];
      root_q <= {root_q[RW-2:0], sq_ge};
      quo_q  <= {quo_q[QW-3:0], 2'b00};
    end
    if (cmd_i.out_load) begin
      sim_q <= sim_n;
      zn_q  <= zero_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zn_q;

endmodule

FILE: src/cosine_vector_similarity.sv
// ----------------------------------------------------------------------------
// Cosine vector similarity
// Streams element pairs of two vectors and returns their cosine in Q1.30.
// ----------------------------------------------------------------------------
// One element pair is taken per cycle while sums accumulate. The request that
// carries the last flag starts the result computation, during which no pair is
// taken: two shift-add products of NW = clog2(MAX_DIM)+31 bits each, a
// 60-bit restoring divide and a 30-bit square root; a saturated or zero-norm
// result skips the divide and root. The multiplier, divider and square root
// are all bit-serial. A finished result waits in an output register, and
// accumulation of the next vectors starts as soon as it has been written
// there.
module cosine_vector_similarity #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] a_elem_i,
  input  logic signed [15:0] b_elem_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] similarity_o,
  output logic               zero_norm_o
);
  import cvs_pkg::*;

  cvs_cmd_t cmd;
  cvs_sts_t sts;

  // Sequencing
  cvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_pair_i (last_pair_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // Arithmetic and result storage
  cvs_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .a_elem_i     (a_elem_i),
    .b_elem_i     (b_elem_i),
    .cmd_i        (cmd),
    .out_ready_i  (out_ready_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o)
  );

  // Hold off input while a result is being computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_pair_i) |=> !in_ready_o)
    else $error("input taken right after a last pair");

  // Keep the result within plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (similarity_o <= 32'sh4000_0000 && similarity_o >= -32'sh4000_0000))
    else $error("similarity out of range");

  // Drive zero similarity for a zero norm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_norm_o) |-> (similarity_o == 32'sd0))
    else $error("zero norm with nonzero similarity");

endmodule

FILE: verif/cvs_checker.sv
// ----------------------------------------------------------------------------
// Cosine similarity checker
// Watches the pair and result channels of the cosine similarity block. It
// keeps its own running dot product and norm sums, computes the expected
// Q1.30 cosine on every last-pair request, and compares each result request
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module cvs_checker #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] a_elem_i,
  input  logic signed [15:0] b_elem_i,
  input  logic               last_pair_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] similarity_i,
  input  logic               zero_norm_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // Each running sum saturates at MAX_DIM, a Q13.30 magnitude at MAX_DIM = 4096
  localparam longint SumCap = longint'(MAX_DIM) << 30;
  localparam int ReportMax = 10;

  typedef struct packed {
    logic signed [31:0] sim;
    logic               zero;
  } cos_result_t;

  cos_result_t cos_want_q[$];
  longint      dot_acc;
  longint      a_norm_acc;
  longint      b_norm_acc;
  int          fails;
  int          pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Clip a running sum to [lo_lim, SumCap]
  function automatic longint sat_sum(input longint v, input longint lo_lim);
    if (v > SumCap) begin
      return SumCap;
    end
    if (v < lo_lim) begin
      return lo_lim;
    end
    return v;
  endfunction

  // Largest r in [0, 2^30] with r*r*na*nb <= dot*dot*2^60, signed as dot
  function automatic logic signed [31:0] cos_ratio_q30(input longint dot,
                                                       input longint na,
                                                       input longint nb);
    logic [191:0] norm_prod;
    logic [191:0] dot_sq;
    logic [191:0] trial;
    logic [63:0]  mag;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    mag = (dot < 0) ? -dot : dot;
    ua = na;
    ub = nb;
    norm_prod = {128'd0, ua} * {128'd0, ub};
    dot_sq = ({128'd0, mag} * {128'd0, mag}) << 60;
    lo = '0;
    hi = 64'd1 << 30;
    // Binary search on the root, comparing in squared form
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 2;
      trial = {128'd0, mid * mid} * norm_prod;
      if (trial <= dot_sq) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return (dot < 0) ? -32'(lo) : 32'(lo);
  endfunction

  // Fold one accepted pair into the sums; queue the cosine on the last pair
  function automatic void accumulate_pair(input logic signed [15:0] a,
                                          input logic signed [15:0] b,
                                          input logic last);
    cos_result_t res;
    dot_acc    = sat_sum(dot_acc + longint'(a) * longint'(b), -SumCap);
    a_norm_acc = sat_sum(a_norm_acc + longint'(a) * longint'(a), 0);
    b_norm_acc = sat_sum(b_norm_acc + longint'(b) * longint'(b), 0);
    if (last) begin
      res.zero = (a_norm_acc == 0) || (b_norm_acc == 0);
      res.sim  = res.zero ? '0 : cos_ratio_q30(dot_acc, a_norm_acc, b_norm_acc);
      cos_want_q.insert(cos_want_q.size(), res);
      dot_acc    = 0;
      a_norm_acc = 0;
      b_norm_acc = 0;
    end
  endfunction

  // Track pair requests and check result requests
  always @(posedge clk_i or negedge rst_ni) begin
    cos_result_t got;
    cos_result_t want;
    if (!rst_ni) begin
      dot_acc    = 0;
      a_norm_acc = 0;
      b_norm_acc = 0;
      cos_want_q.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        accumulate_pair(a_elem_i, b_elem_i, last_pair_i);
      end
      if (out_valid_i && out_ready_i) begin
        got = {similarity_i, zero_norm_i};
        if (cos_want_q.size() == 0) begin
          fails++;
          if (fails <= ReportMax) begin
            $display("unexpected result: sim=%0d zero_norm=%0b", got.sim, got.zero);
          end
        end else begin
          want = cos_want_q.pop_front();
          if (got.sim !== want.sim || got.zero !== want.zero) begin
            fails++;
            if (fails <= ReportMax) begin
              $display("result differs: expected sim=%0d zero_norm=%0b, got sim=%0d zero_norm=%0b",
                       want.sim, want.zero, got.sim, got.zero);
            end
          end
        end
      end
      pending = cos_want_q.size();
    end
  end

endmodule

FILE: verif/cosine_vector_similarity_tb.sv
// ----------------------------------------------------------------------------
// Cosine similarity testbench
// Streams directed and random vector pairs into the block under several
// sender and receiver stall mixes. A separate checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module cosine_vector_similarity_tb;

  localparam int unsigned MaxDim = 4096;
  localparam int RandomPairs = 920;
  // Settling time after the last drain, with margin
  localparam int SettleCycles = 400;
  localparam int CycleLimit = 1000000;

  typedef enum int {
    VecRandom,
    VecSmall,
    VecSame,
    VecNegated,
    VecZeroA,
    VecZeroB,
    VecNear,
    VecScaled
  } vec_kind_e;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] a_elem_i = '0;
  logic signed [15:0] b_elem_i = '0;
  logic               last_pair_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] similarity_o;
  logic               zero_norm_o;

  int fail_count;
  int pending;
  int send_idle_pct = 37;
  int recv_idle_pct = 54;
  int pairs_sent = 0;
  int cycle_cnt;

  cosine_vector_similarity #(
    .MAX_DIM(MaxDim)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_elem_i    (a_elem_i),
    .b_elem_i    (b_elem_i),
    .last_pair_i (last_pair_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .similarity_o(similarity_o),
    .zero_norm_o (zero_norm_o)
  );

  cvs_checker #(
    .MAX_DIM(MaxDim)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .a_elem_i    (a_elem_i),
    .b_elem_i    (b_elem_i),
    .last_pair_i (last_pair_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .similarity_i(similarity_o),
    .zero_norm_i (zero_norm_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if it hangs
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("cosine_vector_similarity: mismatch");
    $finish;
  end

  // Send one pair request; enter and leave at a falling edge
  task automatic push_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    a_elem_i    <= a;
    b_elem_i    <= b;
    last_pair_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  // Send one vector pair whose content follows the given kind
  task automatic push_vector(input vec_kind_e kind, input int len);
    logic signed [15:0] a;
    logic signed [15:0] b;
    int shift;
    shift = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (kind)
        VecSmall: begin
          a = 16'($urandom_range(0, 32)) - 16'sd16;
          b = 16'($urandom_range(0, 32)) - 16'sd16;
        end
        VecSame:    b = a;
        VecNegated: b = -a;
        VecZeroA:   a = '0;
        VecZeroB:   b = '0;
        VecNear:    b = a + 16'($urandom_range(0, 6)) - 16'sd3;
        VecScaled:  b = a >>> shift;
        default: ;
      endcase
      push_pair(a, b, i == len - 1);
    end
  endtask

  // Hold off new pairs until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int r;
    int len;
    int rand_start;
    vec_kind_e kind;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single pairs: full-scale agreement and opposition
    push_pair(16'sh7fff, 16'sh7fff, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 1'b1);
    push_pair(16'sh8000, 16'sh7fff, 1'b1);
    push_pair(16'shffff, 16'shffff, 1'b1);
    push_pair(16'sh0001, 16'shffff, 1'b1);
    // Zero norm on either side and on both
    push_pair(16'sh0000, 16'sh1234, 1'b1);
    push_pair(16'sh4321, 16'sh0000, 1'b1);
    push_pair(16'sh0000, 16'sh0000, 1'b1);
    // Orthogonal vectors
    push_pair(16'sh0001, 16'sh0000, 1'b0);
    push_pair(16'sh0000, 16'sh0001, 1'b1);
    push_pair(16'sh0001, 16'sh0001, 1'b0);
    push_pair(-16'sd1, 16'sh0001, 1'b1);
    // Small cosine and a general mix
    push_pair(16'sh7fff, 16'sh0001, 1'b0);
    push_pair(16'sh0001, 16'sh7fff, 1'b1);
    push_pair(-16'sd5, 16'sd7, 1'b0);
    push_pair(16'sd100, -16'sd3, 1'b0);
    push_pair(16'sh8000, 16'sd12345, 1'b1);
    drain_results();

    // Random vectors in three stall mixes
    rand_start = pairs_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (pairs_sent - rand_start < (phase + 1) * RandomPairs / 3) begin
        r = $urandom_range(99);
        if (r < 70) begin
          len = $urandom_range(1, 8);
        end else if (r < 95) begin
          len = $urandom_range(9, 40);
        end else begin
          len = $urandom_range(41, 160);
        end
        if ($urandom_range(99) < 40) begin
          kind = VecRandom;
        end else begin
          kind = vec_kind_e'($urandom_range(VecSmall, VecScaled));
        end
        push_vector(kind, len);
      end
      drain_results();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("cosine_vector_similarity: match");
    end else begin
      $display("cosine_vector_similarity: mismatch");
    end
    $finish;
  end

endmodule
